// ----- rtl/sm83_pkg.sv -----
// sm83_pkg: payload structs, modes, opcodes, flag positions and cfg addresses for sm83_instruction_step.
// No dependencies.
`default_nettype none
package sm83_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  data;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  flags;
    logic [7:0]  reg_b;
    logic [7:0]  reg_c;
    logic [7:0]  reg_d;
    logic [7:0]  reg_e;
    logic [7:0]  reg_h;
    logic [7:0]  reg_l;
    logic [15:0] prog_counter;
    logic [15:0] stack_ptr;
    logic [7:0]  opcode_seen;
    logic        unknown_op;
  } out_beat_t;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_EXEC    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [7:0] OP_NOP    = 8'h00;
  localparam logic [7:0] OP_LD_BC  = 8'h01;
  localparam logic [7:0] OP_INC_BC = 8'h03;
  localparam logic [7:0] OP_LD_B   = 8'h06;
  localparam logic [7:0] OP_DEC_BC = 8'h0B;
  localparam logic [7:0] OP_JR_NZ  = 8'h20;
  localparam logic [7:0] OP_JR_Z   = 8'h28;
  localparam logic [7:0] OP_JR_NC  = 8'h30;
  localparam logic [7:0] OP_JR_C   = 8'h38;
  localparam logic [7:0] OP_INC_A  = 8'h3C;
  localparam logic [7:0] OP_LD_A   = 8'h3E;
  localparam logic [7:0] OP_POP_BC = 8'hC1;
  localparam logic [7:0] OP_JP_NZ  = 8'hC2;
  localparam logic [7:0] OP_JP     = 8'hC3;
  localparam logic [7:0] OP_PUSH_BC = 8'hC5;
  localparam logic [7:0] OP_RET    = 8'hC9;
  localparam logic [7:0] OP_JP_Z   = 8'hCA;
  localparam logic [7:0] OP_CALL   = 8'hCD;
  localparam logic [7:0] OP_POP_DE = 8'hD1;
  localparam logic [7:0] OP_JP_NC  = 8'hD2;
  localparam logic [7:0] OP_PUSH_DE = 8'hD5;
  localparam logic [7:0] OP_JP_C   = 8'hDA;
  localparam logic [7:0] OP_POP_HL = 8'hE1;
  localparam logic [7:0] OP_PUSH_HL = 8'hE5;
  localparam logic [7:0] OP_POP_AF = 8'hF1;
  localparam logic [7:0] OP_PUSH_AF = 8'hF5;
  localparam logic [7:0] OP_CP     = 8'hFE;

  // flag_reg bit positions (ZNHC)
  localparam int FZ = 3;
  localparam int FN = 2;
  localparam int FH = 1;
  localparam int FC = 0;

  localparam logic [1:0] CFG_START_PC  = 2'd0;
  localparam logic [1:0] CFG_START_SP  = 2'd1;
  localparam logic [1:0] CFG_START_ACC = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/sm83_instruction_step.sv -----
// sm83_instruction_step: SM83 core subset with a single-port byte memory.
// Depends on sm83_pkg.
`default_nettype none
// Channel | Dir | Handshake                   | Payload
// in      | in  | in_valid_i / in_ready_o     | sm83_pkg::in_beat_t
// out     | out | out_valid_o / out_ready_i   | sm83_pkg::out_beat_t
// cfg     | in  | APB psel/penable/pwrite     | start_pc, start_sp, start_acc
//
// A memory write beat and a restart are each handled in the idle state. An instruction
// reads its opcode, operand or popped bytes, then writes any pushed bytes, on the one memory port.
// Each read is issued and its data lands in the next cycle, from a registered read.
// Reset clears core registers and control; memory content is undefined until written.
// The result sits in an output register; the next beat is accepted while it waits, and
// stalls during an instruction and when a new result is ready with the register full.
module sm83_instruction_step #(
  parameter int ADDR_BITS = 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  sm83_pkg::in_beat_t     in_data_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output sm83_pkg::out_beat_t    out_data_o,
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire [3:0]              paddr,
  input  wire [31:0]             pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import sm83_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OPC   = 3'd1; // opcode byte arrives
  localparam logic [2:0] S_OPR1  = 3'd2; // first operand / pop low arrives
  localparam logic [2:0] S_OPR2  = 3'd3; // second operand / pop high arrives
  localparam logic [2:0] S_PUSHH = 3'd4; // write high byte
  localparam logic [2:0] S_PUSHL = 3'd5; // write low byte
  localparam logic [2:0] S_DONE  = 3'd6; // result waits for output register

  logic [7:0] mem [2**ADDR_BITS];
  logic [7:0] rdata_q;

  logic [15:0] start_pc_q, start_sp_q;
  logic [7:0]  start_acc_q;

  logic [7:0]  acc_q, acc_d;
  logic [3:0]  flg_q, flg_d;
  logic [7:0]  b_q, c_q, d_q, e_q, h_q, l_q;
  logic [7:0]  b_d, c_d, d_d, e_d, h_d, l_d;
  logic [15:0] pc_q, pc_d, sp_q, sp_d;
  logic [2:0]  st_q, st_d;
  logic [7:0]  op_q, op_d;
  logic [7:0]  lo_q, lo_d;
  logic [15:0] wv_q, wv_d;    // word to push
  logic        unk_q, unk_d;
  logic        res_d;         // a result is complete this cycle

  logic        mem_we, mem_re;
  logic [15:0] mem_a;
  logic [7:0]  mem_wd;

  logic        ov_q;
  out_beat_t   ob_q;

  logic in_fire, out_free;
  assign out_free   = !ov_q || out_ready_i;
  assign in_ready_o = (st_q == S_IDLE) && !(st_q == S_DONE);
  assign in_fire    = in_valid_i && in_ready_o;

  // APB
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  always_comb begin
    unique case (paddr[3:2])
      CFG_START_PC:  prdata = {16'h0, start_pc_q};
      CFG_START_SP:  prdata = {16'h0, start_sp_q};
      CFG_START_ACC: prdata = {24'h0, start_acc_q};
      default:       prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pc_q  <= 16'd336;
      start_sp_q  <= 16'hFFFE;
      start_acc_q <= 8'd42;
    end else if (cfg_we) begin
      case (paddr[3:2])
        CFG_START_PC:  start_pc_q  <= pwdata[15:0];
        CFG_START_SP:  start_sp_q  <= pwdata[15:0];
        CFG_START_ACC: start_acc_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // memory: one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_a[ADDR_BITS-1:0]] <= mem_wd;
    if (mem_re) rdata_q <= mem[mem_a[ADDR_BITS-1:0]];
  end

  logic take;
  always_comb begin
    acc_d = acc_q; flg_d = flg_q;
    b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q; h_d = h_q; l_d = l_q;
    pc_d = pc_q; sp_d = sp_q; st_d = st_q; op_d = op_q; lo_d = lo_q;
    wv_d = wv_q; unk_d = unk_q; res_d = 1'b0;
    mem_we = 1'b0; mem_re = 1'b0; mem_a = pc_q; mem_wd = 8'h0;
    take = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data_i.mode)
            MODE_WRITE: begin
              mem_we = 1'b1; mem_a = in_data_i.address; mem_wd = in_data_i.data;
            end
            MODE_EXEC: begin
              mem_re = 1'b1; mem_a = pc_q; pc_d = pc_q + 16'd1; st_d = S_OPC;
            end
            MODE_RESTART: begin
              acc_d = start_acc_q; flg_d = 4'h0;
              {b_d, c_d, d_d, e_d, h_d, l_d} = '0;
              pc_d = start_pc_q; sp_d = start_sp_q;
              op_d = 8'h00; unk_d = 1'b0; res_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_OPC: begin
        op_d = rdata_q; unk_d = 1'b0; res_d = 1'b1; st_d = S_IDLE;
        case (rdata_q)
          OP_NOP: ;
          OP_LD_BC, OP_LD_B, OP_LD_A, OP_CP, OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C,
          OP_JP, OP_JP_NZ, OP_JP_Z, OP_JP_NC, OP_JP_C, OP_CALL: begin
            mem_re = 1'b1; mem_a = pc_q; pc_d = pc_q + 16'd1;
            res_d = 1'b0; st_d = S_OPR1;
          end
          OP_RET, OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF: begin
            mem_re = 1'b1; mem_a = sp_q; sp_d = sp_q + 16'd1;
            res_d = 1'b0; st_d = S_OPR1;
          end
          OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF: begin
            case (rdata_q)
              OP_PUSH_BC: wv_d = {b_q, c_q};
              OP_PUSH_DE: wv_d = {d_q, e_q};
              OP_PUSH_HL: wv_d = {h_q, l_q};
              default:    wv_d = {acc_q, flg_q, 4'h0};
            endcase
            res_d = 1'b0; st_d = S_PUSHH;
          end
          OP_INC_A: begin
            flg_d = {acc_q == 8'hFF, 1'b0, acc_q[3:0] == 4'hF, flg_q[FC]};
            acc_d = acc_q + 8'd1;
          end
          OP_INC_BC: {b_d, c_d} = {b_q, c_q} + 16'd1;
          OP_DEC_BC: {b_d, c_d} = {b_q, c_q} - 16'd1;
          default: unk_d = 1'b1;
        endcase
      end
      S_OPR1: begin
        lo_d = rdata_q; res_d = 1'b1; st_d = S_IDLE;
        case (op_q)
          OP_LD_B: b_d = rdata_q;
          OP_LD_A: acc_d = rdata_q;
          OP_CP: flg_d = {acc_q == rdata_q, 1'b1, acc_q[3:0] < rdata_q[3:0],
                          acc_q < rdata_q};
          OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C: begin
            case (op_q)
              OP_JR_NZ: take = !flg_q[FZ];
              OP_JR_Z:  take = flg_q[FZ];
              OP_JR_NC: take = !flg_q[FC];
              default:  take = flg_q[FC];
            endcase
            if (take) pc_d = pc_q + {{8{rdata_q[7]}}, rdata_q};
          end
          OP_RET, OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF: begin
            mem_re = 1'b1; mem_a = sp_q; sp_d = sp_q + 16'd1;
            res_d = 1'b0; st_d = S_OPR2;
          end
          default: begin
            mem_re = 1'b1; mem_a = pc_q; pc_d = pc_q + 16'd1;
            res_d = 1'b0; st_d = S_OPR2;
          end
        endcase
      end
      S_OPR2: begin
        res_d = 1'b1; st_d = S_IDLE;
        case (op_q)
          OP_LD_BC, OP_POP_BC: {b_d, c_d} = {rdata_q, lo_q};
          OP_POP_DE: {d_d, e_d} = {rdata_q, lo_q};
          OP_POP_HL: {h_d, l_d} = {rdata_q, lo_q};
          OP_POP_AF: begin acc_d = rdata_q; flg_d = lo_q[7:4]; end
          OP_RET, OP_JP: pc_d = {rdata_q, lo_q};
          OP_JP_NZ: if (!flg_q[FZ]) pc_d = {rdata_q, lo_q};
          OP_JP_Z:  if (flg_q[FZ])  pc_d = {rdata_q, lo_q};
          OP_JP_NC: if (!flg_q[FC]) pc_d = {rdata_q, lo_q};
          OP_JP_C:  if (flg_q[FC])  pc_d = {rdata_q, lo_q};
          default: begin // CALL: jump, then push return address
            wv_d = pc_q; pc_d = {rdata_q, lo_q}; res_d = 1'b0; st_d = S_PUSHH;
          end
        endcase
      end
      S_PUSHH: begin
        mem_we = 1'b1; mem_a = sp_q - 16'd1; mem_wd = wv_q[15:8];
        sp_d = sp_q - 16'd1; st_d = S_PUSHL;
      end
      S_PUSHL: begin
        mem_we = 1'b1; mem_a = sp_q - 16'd1; mem_wd = wv_q[7:0];
        sp_d = sp_q - 16'd1; res_d = 1'b1; st_d = S_IDLE;
      end
      S_DONE: begin
        if (out_free) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
    // result with output register full: hold in S_DONE until it drains
    if (res_d && !out_free) st_d = S_DONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; acc_q <= '0; flg_q <= '0;
      b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0; h_q <= '0; l_q <= '0;
      pc_q <= '0; sp_q <= '0; op_q <= '0; unk_q <= 1'b0; lo_q <= '0; wv_q <= '0;
    end else begin
      st_q <= st_d; acc_q <= acc_d; flg_q <= flg_d;
      b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d; h_q <= h_d; l_q <= l_d;
      pc_q <= pc_d; sp_q <= sp_d; op_q <= op_d; unk_q <= unk_d; lo_q <= lo_d; wv_q <= wv_d;
    end
  end

  // output register; a result parked in S_DONE is loaded once it frees
  logic load_out;
  assign load_out = (res_d || st_q == S_DONE) && out_free;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (load_out) ov_q <= 1'b1;
    else if (out_ready_i) ov_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ob_q <= '{acc: acc_d, flags: {flg_d, 4'h0}, reg_b: b_d, reg_c: c_d,
                reg_d: d_d, reg_e: e_d, reg_h: h_d, reg_l: l_d,
                prog_counter: pc_d, stack_ptr: sp_d, opcode_seen: op_d,
                unknown_op: unk_d};
    end
  end
  assign out_valid_o = ov_q;
  assign out_data_o  = ob_q;
endmodule
`default_nettype wire
